// File: hw/rtl/dsc_pkg.sv
// ----------------------------------------------------------------------------
// Delta sample channel package
// Shared types, constants and the timer period tables of the channel.
// ----------------------------------------------------------------------------
package dsc_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_FETCH  = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_CONTROL = 3'd0,
    REG_LEVEL   = 3'd1,
    REG_ADDRESS = 3'd2,
    REG_LENGTH  = 3'd3,
    REG_ENABLE  = 3'd4
  } reg_sel_e;

  typedef enum logic [0:0] {
    CFG_REGION = 1'b0,
    CFG_ENABLE = 1'b1
  } cfg_idx_e;

  localparam logic [1:0]  RegionSecond = 2'd1;
  localparam logic [6:0]  LevelUpLimit = 7'h7D;
  localparam logic [15:0] AddrBase     = 16'hC000;
  localparam logic [15:0] AddrWrap     = 16'h8000;
  localparam logic [15:0] AddrLast     = 16'hFFFF;

  function automatic logic [8:0] rate_period(input logic second, input logic [3:0] idx);
    logic [8:0] p;
    if (second) begin
      unique case (idx)
        4'd0:  p = 9'd398;
        4'd1:  p = 9'd354;
        4'd2:  p = 9'd316;
        4'd3:  p = 9'd298;
        4'd4:  p = 9'd276;
        4'd5:  p = 9'd236;
        4'd6:  p = 9'd210;
        4'd7:  p = 9'd198;
        4'd8:  p = 9'd176;
        4'd9:  p = 9'd148;
        4'd10: p = 9'd132;
        4'd11: p = 9'd118;
        4'd12: p = 9'd98;
        4'd13: p = 9'd78;
        4'd14: p = 9'd66;
        default: p = 9'd50;
      endcase
    end else begin
      unique case (idx)
        4'd0:  p = 9'd428;
        4'd1:  p = 9'd380;
        4'd2:  p = 9'd340;
        4'd3:  p = 9'd320;
        4'd4:  p = 9'd286;
        4'd5:  p = 9'd254;
        4'd6:  p = 9'd226;
        4'd7:  p = 9'd214;
        4'd8:  p = 9'd190;
        4'd9:  p = 9'd160;
        4'd10: p = 9'd142;
        4'd11: p = 9'd128;
        4'd12: p = 9'd106;
        4'd13: p = 9'd84;
        4'd14: p = 9'd72;
        default: p = 9'd54;
      endcase
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/delta_sample_channel_top.sv
// ----------------------------------------------------------------------------
// Delta sample channel
// One-bit delta-modulation sample channel with its fetch and length logic.
// ----------------------------------------------------------------------------
// The channel takes one transaction per clock while the result register is
// not stalled, and returns one result for each: a transaction passes through
// the input register and then the result register. The single update stage
// between these registers sets the rate, and a stalled result register holds further input back.
module delta_sample_channel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  reg_select_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  fetched_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  sample_out_o,
  output logic        fetch_request_o,
  output logic [15:0] fetch_address_o,
  output logic        irq_o,
  output logic [7:0]  read_data_o
);

  logic [1:0]  region_q;
  logic        chan_en_q;

  logic        in_valid_q;
  logic [1:0]  kind_q;
  logic [2:0]  reg_sel_q;
  logic [7:0]  data_q;
  logic [7:0]  fetched_q;

  logic        out_valid_q;
  logic [6:0]  sample_q;
  logic        req_q;
  logic [15:0] addr_out_q;
  logic        irq_out_q;
  logic [7:0]  rdata_q;

  logic [6:0]  level_q, level_d;
  logic [6:0]  held_q, held_d;
  logic [8:0]  period_q, period_d;
  logic        irq_en_q, irq_en_d;
  logic        loop_q, loop_d;
  logic [3:0]  rate_idx_q, rate_idx_d;
  logic [15:0] cur_addr_q, cur_addr_d;
  logic [15:0] start_addr_q, start_addr_d;
  logic [11:0] start_len_q, start_len_d;
  logic [11:0] remain_q, remain_d;
  logic [3:0]  bits_left_q, bits_left_d;
  logic [7:0]  shift_q, shift_d;
  logic        playing_q, playing_d;
  logic        buf_full_q, buf_full_d;
  logic [7:0]  sample_buf_q, sample_buf_d;
  logic        irq_flag_q, irq_flag_d;
  logic        req_d;
  logic [7:0]  rdata_d;

  logic        advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    logic [3:0] bl;
    level_d      = level_q;
    held_d       = held_q;
    period_d     = period_q;
    irq_en_d     = irq_en_q;
    loop_d       = loop_q;
    rate_idx_d   = rate_idx_q;
    cur_addr_d   = cur_addr_q;
    start_addr_d = start_addr_q;
    start_len_d  = start_len_q;
    remain_d     = remain_q;
    bits_left_d  = bits_left_q;
    shift_d      = shift_q;
    playing_d    = playing_q;
    buf_full_d   = buf_full_q;
    sample_buf_d = sample_buf_q;
    irq_flag_d   = irq_flag_q;
    req_d        = 1'b0;
    rdata_d      = 8'h00;
    bl           = bits_left_q - 4'd1;
    unique case (dsc_pkg::kind_e'(kind_q))
      dsc_pkg::KIND_TICK: begin
        if (period_q > 9'd1) begin
          period_d = period_q - 9'd1;
        end else begin
          period_d = dsc_pkg::rate_period(region_q == dsc_pkg::RegionSecond, rate_idx_q);
          if (playing_q) begin
            if (shift_q[0]) begin
              if (level_q <= dsc_pkg::LevelUpLimit) level_d = level_q + 7'd2;
            end else begin
              if (level_q >= 7'd2) level_d = level_q - 7'd2;
            end
            shift_d = {1'b0, shift_q[7:1]};
          end
          bits_left_d = bl;
          if (bl == 4'd0) begin
            bits_left_d = 4'd8;
            if (buf_full_q) begin
              buf_full_d = 1'b0;
              playing_d  = 1'b1;
              shift_d    = sample_buf_q;
              req_d      = (remain_q != 12'd0);
            end else begin
              playing_d = 1'b0;
            end
          end
          if (chan_en_q) held_d = level_d;
        end
      end
      dsc_pkg::KIND_WRITE: begin
        unique case (reg_sel_q)
          dsc_pkg::REG_CONTROL: begin
            irq_en_d   = data_q[7];
            loop_d     = data_q[6];
            rate_idx_d = data_q[3:0];
            if (!data_q[7]) irq_flag_d = 1'b0;
          end
          dsc_pkg::REG_LEVEL: level_d = data_q[6:0];
          dsc_pkg::REG_ADDRESS: start_addr_d = {2'b11, data_q, 6'd0};
          dsc_pkg::REG_LENGTH: start_len_d = {data_q, 4'h1};
          dsc_pkg::REG_ENABLE: begin
            if (data_q[4]) begin
              if (remain_q == 12'd0) begin
                remain_d   = start_len_q;
                cur_addr_d = start_addr_q;
              end
            end else begin
              remain_d = 12'd0;
            end
            irq_flag_d = 1'b0;
            req_d      = !buf_full_q && (remain_d != 12'd0);
          end
          default: ;
        endcase
      end
      dsc_pkg::KIND_FETCH: begin
        buf_full_d   = 1'b1;
        sample_buf_d = fetched_q;
        cur_addr_d   = (cur_addr_q == dsc_pkg::AddrLast) ? dsc_pkg::AddrWrap
                                                         : cur_addr_q + 16'd1;
        if (remain_q != 12'd0) remain_d = remain_q - 12'd1;
        if (remain_d == 12'd0) begin
          if (loop_q) begin
            remain_d   = start_len_q;
            cur_addr_d = start_addr_q;
          end else if (irq_en_q) begin
            irq_flag_d = 1'b1;
          end
        end
      end
      dsc_pkg::KIND_STATUS: begin
        rdata_d = (remain_q != 12'd0) ? (data_q | 8'h10) : data_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q  <= 2'd0;
      chan_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (dsc_pkg::cfg_idx_e'(cfg_index_i))
        dsc_pkg::CFG_REGION: region_q  <= cfg_data_i;
        dsc_pkg::CFG_ENABLE: chan_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      kind_q    <= kind_i;
      reg_sel_q <= reg_select_i;
      data_q    <= data_byte_i;
      fetched_q <= fetched_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q      <= 7'd0;
      held_q       <= 7'd0;
      period_q     <= 9'd0;
      irq_en_q     <= 1'b0;
      loop_q       <= 1'b0;
      rate_idx_q   <= 4'd0;
      cur_addr_q   <= dsc_pkg::AddrBase;
      start_addr_q <= dsc_pkg::AddrBase;
      start_len_q  <= 12'd0;
      remain_q     <= 12'd0;
      bits_left_q  <= 4'd1;
      shift_q      <= 8'd1;
      playing_q    <= 1'b0;
      buf_full_q   <= 1'b0;
      irq_flag_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        level_q      <= level_d;
        held_q       <= held_d;
        period_q     <= period_d;
        irq_en_q     <= irq_en_d;
        loop_q       <= loop_d;
        rate_idx_q   <= rate_idx_d;
        cur_addr_q   <= cur_addr_d;
        start_addr_q <= start_addr_d;
        start_len_q  <= start_len_d;
        remain_q     <= remain_d;
        bits_left_q  <= bits_left_d;
        shift_q      <= shift_d;
        playing_q    <= playing_d;
        buf_full_q   <= buf_full_d;
        irq_flag_q   <= irq_flag_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sample_buf_q <= sample_buf_d;
      sample_q     <= held_d;
      req_q        <= req_d;
      addr_out_q   <= cur_addr_d;
      irq_out_q    <= irq_flag_d;
      rdata_q      <= rdata_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = sample_q;
  assign fetch_request_o = req_q;
  assign fetch_address_o = addr_out_q;
  assign irq_o           = irq_out_q;
  assign read_data_o     = rdata_q;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delta sample channel testbench
// Sends ticks, register writes, fetched bytes and status reads into the
// channel with random idle cycles and output stalls. A local copy of the
// channel state predicts every result, and each output field is compared in
// order of arrival.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CtrlIrqBit = 7;
  localparam int CtrlLoopBit = 6;
  localparam int LengthBit = 4;
  localparam logic [2:0] RegUnusedLo = 3'd5;
  localparam logic [2:0] RegUnusedHi = 3'd7;
  localparam int PhaseOps = 160;
  localparam int NumPhases = 8;
  localparam logic [8:0] PeriodFirst [16] = '{
    9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
    9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd84, 9'd72, 9'd54
  };
  localparam logic [8:0] PeriodSecond [16] = '{
    9'd398, 9'd354, 9'd316, 9'd298, 9'd276, 9'd236, 9'd210, 9'd198,
    9'd176, 9'd148, 9'd132, 9'd118, 9'd98, 9'd78, 9'd66, 9'd50
  };

  typedef struct {
    dsc_pkg::kind_e kind;
    logic [2:0]     sel;
    logic [7:0]     data;
    logic [7:0]     fetched;
    bit             drain_first;
  } item_t;

  typedef struct packed {
    logic [6:0]  sample;
    logic        req;
    logic [15:0] addr;
    logic        irq;
    logic [7:0]  rdata;
  } chan_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [1:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [2:0]  reg_select_i;
  logic [7:0]  data_byte_i;
  logic [7:0]  fetched_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [6:0]  sample_out_o;
  logic        fetch_request_o;
  logic [15:0] fetch_address_o;
  logic        irq_o;
  logic [7:0]  read_data_o;

  delta_sample_channel_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .reg_select_i   (reg_select_i),
    .data_byte_i    (data_byte_i),
    .fetched_byte_i (fetched_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o),
    .fetch_request_o(fetch_request_o),
    .fetch_address_o(fetch_address_o),
    .irq_o          (irq_o),
    .read_data_o    (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Channel state as seen by the predictor.
  logic [1:0]  cfg_region = 2'd0;
  logic        cfg_enable = 1'b1;
  logic [6:0]  lvl = '0;
  logic [6:0]  held = '0;
  logic [8:0]  period_left = '0;
  logic        irq_en = 1'b0;
  logic        loop_md = 1'b0;
  logic [3:0]  rate_idx = '0;
  logic [15:0] cur_addr = dsc_pkg::AddrBase;
  logic [15:0] start_addr = dsc_pkg::AddrBase;
  logic [11:0] start_len = '0;
  logic [11:0] remain = '0;
  logic [3:0]  bits_left = 4'd1;
  logic [7:0]  shifter = 8'd1;
  logic        playing = 1'b0;
  logic        buf_full = 1'b0;
  logic [7:0]  buf_byte = '0;
  logic        irq_flag = 1'b0;

  item_t        bus_items[$];
  chan_result_t channel_results[$];
  item_t        cur;
  chan_result_t want;
  bit           took = 1'b0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           tx_calm = 0;
  int           rx_calm = 0;
  int           errors = 0;
  int           n_items = 0;
  int           n_ticks = 0;
  int           expiries = 0;
  int           requests = 0;
  int           wraps = 0;

  function automatic chan_result_t step_channel(item_t it);
    chan_result_t r;
    r = '0;
    case (it.kind)
      dsc_pkg::KIND_TICK: begin
        n_ticks++;
        if (period_left > 9'd1) begin
          period_left--;
        end else begin
          expiries++;
          period_left = (cfg_region == dsc_pkg::RegionSecond) ? PeriodSecond[rate_idx]
                                                              : PeriodFirst[rate_idx];
          if (playing) begin
            if (shifter[0]) begin
              if (lvl <= dsc_pkg::LevelUpLimit) lvl += 7'd2;
            end else if (lvl >= 7'd2) begin
              lvl -= 7'd2;
            end
            shifter = shifter >> 1;
          end
          bits_left--;
          if (bits_left == 4'd0) begin
            bits_left = 4'd8;
            if (buf_full) begin
              buf_full = 1'b0;
              playing = 1'b1;
              shifter = buf_byte;
              r.req = (remain != '0);
            end else begin
              playing = 1'b0;
            end
          end
          if (cfg_enable) held = lvl;
        end
      end
      dsc_pkg::KIND_WRITE: begin
        case (it.sel)
          dsc_pkg::REG_CONTROL: begin
            irq_en = it.data[CtrlIrqBit];
            loop_md = it.data[CtrlLoopBit];
            if (!irq_en) irq_flag = 1'b0;
            rate_idx = it.data[3:0];
          end
          dsc_pkg::REG_LEVEL: lvl = it.data[6:0];
          dsc_pkg::REG_ADDRESS: start_addr = dsc_pkg::AddrBase | {2'b00, it.data, 6'b000000};
          dsc_pkg::REG_LENGTH: start_len = {it.data, 4'b0001};
          dsc_pkg::REG_ENABLE: begin
            if (it.data[LengthBit]) begin
              if (remain == '0) begin
                remain = start_len;
                cur_addr = start_addr;
              end
            end else begin
              remain = '0;
            end
            irq_flag = 1'b0;
            r.req = !buf_full && (remain != '0);
          end
          default: ;
        endcase
      end
      dsc_pkg::KIND_FETCH: begin
        buf_full = 1'b1;
        buf_byte = it.fetched;
        if (cur_addr == dsc_pkg::AddrLast) begin
          cur_addr = dsc_pkg::AddrWrap;
          wraps++;
        end else begin
          cur_addr++;
        end
        if (remain != '0) remain--;
        if (remain == '0) begin
          if (loop_md) begin
            remain = start_len;
            cur_addr = start_addr;
          end else if (irq_en) begin
            irq_flag = 1'b1;
          end
        end
      end
      default: begin
        r.rdata = it.data;
        if (remain != '0) r.rdata[LengthBit] = 1'b1;
      end
    endcase
    r.sample = held;
    r.addr = cur_addr;
    r.irq = irq_flag;
    if (r.req) requests++;
    return r;
  endfunction

  function automatic int idle_len(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_left = $urandom_range(40, 200);
    if (r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        took = 1'b1;
        n_items++;
        channel_results.push_back(step_channel(cur));
      end
      if (out_valid_o && !out_stall_i) begin
        if (channel_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, got %0h",
                   $time, {sample_out_o, fetch_request_o, fetch_address_o, irq_o, read_data_o});
        end else begin
          want = channel_results.pop_front();
          check_field("sample_out", 16'(want.sample), 16'(sample_out_o));
          check_field("fetch_request", 16'(want.req), 16'(fetch_request_o));
          check_field("fetch_address", want.addr, fetch_address_o);
          check_field("irq", 16'(want.irq), 16'(irq_o));
          check_field("read_data", 16'(want.rdata), 16'(read_data_o));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took)) begin
      took = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (bus_items.size() > 0 &&
                   !(bus_items[0].drain_first && channel_results.size() > 0)) begin
        cur = bus_items.pop_front();
        kind_i <= cur.kind;
        reg_select_i <= cur.sel;
        data_byte_i <= cur.data;
        fetched_byte_i <= cur.fetched;
        in_valid_i <= 1'b1;
        send_gap = idle_len(tx_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = idle_len(rx_calm);
      end
    end
  end

  task automatic add_item(dsc_pkg::kind_e k, logic [2:0] s, logic [7:0] d, logic [7:0] f);
    item_t it;
    it.kind = k;
    it.sel = s;
    it.data = d;
    it.fetched = f;
    if (k != dsc_pkg::KIND_WRITE) it.sel = 3'($urandom);
    if (k == dsc_pkg::KIND_TICK || k == dsc_pkg::KIND_FETCH) it.data = 8'($urandom);
    if (k != dsc_pkg::KIND_FETCH) it.fetched = 8'($urandom);
    it.drain_first = ($urandom_range(0, 79) == 0);
    bus_items.push_back(it);
  endtask

  task automatic write_cfg(dsc_pkg::cfg_idx_e idx, logic [1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx == dsc_pkg::CFG_REGION) cfg_region = val;
    else cfg_enable = val[0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (bus_items.size() > 0 || in_valid_i || channel_results.size() > 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic gen_phase(int ops);
    int base;
    int done;
    int body;
    int op;
    logic [7:0] d;
    base = bus_items.size();
    done = 0;
    while (done < ops) begin
      if ($urandom_range(0, 99) < 85) begin
        d = 8'($urandom);
        if ($urandom_range(0, 4) != 0) d[3:0] = 4'($urandom_range(12, 15));
        add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_CONTROL, d, '0);
        if ($urandom_range(0, 1)) begin
          d = 8'($urandom);
          if ($urandom_range(0, 1)) d[6:1] = {6{d[0]}};
          add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_LEVEL, d, '0);
        end
        d = ($urandom_range(0, 6) == 0) ? 8'hFF : 8'($urandom);
        add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_ADDRESS, d, '0);
        d = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_LENGTH, d, '0);
        d = 8'($urandom);
        d[LengthBit] = 1'b1;
        add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_ENABLE, d, '0);
        body = $urandom_range(10, 40);
        repeat (body) begin
          if (bus_items.size() - base >= ops) break;
          op = $urandom_range(0, 99);
          if (op < 55) begin
            repeat ($urandom_range(1, 64)) add_item(dsc_pkg::KIND_TICK, '0, '0, '0);
          end else if (op < 75) begin
            add_item(dsc_pkg::KIND_FETCH, '0, '0, 8'($urandom));
          end else if (op < 78) begin
            repeat ($urandom_range(20, 70)) begin
              add_item(dsc_pkg::KIND_FETCH, '0, '0, 8'($urandom));
            end
          end else if (op < 88) begin
            add_item(dsc_pkg::KIND_STATUS, '0, 8'($urandom), '0);
          end else begin
            add_item(dsc_pkg::KIND_WRITE, 3'($urandom_range(0, 7)), 8'($urandom), '0);
          end
        end
      end else begin
        body = $urandom_range(10, 30);
        repeat (body) begin
          add_item(dsc_pkg::kind_e'($urandom_range(0, 3)), 3'($urandom), 8'($urandom),
                   8'($urandom));
        end
      end
      done = bus_items.size() - base;
    end
  endtask

  initial begin
    int p;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = dsc_pkg::CFG_REGION;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = dsc_pkg::KIND_TICK;
    reg_select_i = '0;
    data_byte_i = '0;
    fetched_byte_i = '0;
    out_stall_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The first tick finds the timer at zero and expires at once.
    add_item(dsc_pkg::KIND_TICK, '0, '0, '0);
    add_item(dsc_pkg::KIND_STATUS, '0, 8'hFF, '0);
    add_item(dsc_pkg::KIND_WRITE, RegUnusedLo, 8'hFF, '0);
    add_item(dsc_pkg::KIND_WRITE, RegUnusedHi, 8'h00, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_CONTROL, 8'hCF, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_LEVEL, 8'hFF, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_ADDRESS, 8'hFF, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_LENGTH, 8'h00, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_ENABLE, 8'h10, '0);
    add_item(dsc_pkg::KIND_STATUS, '0, 8'h00, '0);
    add_item(dsc_pkg::KIND_FETCH, '0, '0, 8'hAA);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_CONTROL, 8'h80, '0);
    add_item(dsc_pkg::KIND_FETCH, '0, '0, 8'hFF);
    add_item(dsc_pkg::KIND_STATUS, '0, 8'hFF, '0);
    // A fetch that nobody asked for, with the length already at zero.
    add_item(dsc_pkg::KIND_FETCH, '0, '0, 8'h00);
    add_item(dsc_pkg::KIND_STATUS, '0, 8'hEF, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_CONTROL, 8'h00, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_CONTROL, 8'h8F, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_ENABLE, 8'h10, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_ENABLE, 8'h00, '0);
    add_item(dsc_pkg::KIND_WRITE, dsc_pkg::REG_LEVEL, 8'h00, '0);
    add_item(dsc_pkg::KIND_TICK, '0, '0, '0);
    bus_items[10].drain_first = 1'b1;
    wait_idle();

    for (p = 0; p < NumPhases; p++) begin
      write_cfg(dsc_pkg::CFG_REGION, 2'(p + 1));
      write_cfg(dsc_pkg::CFG_ENABLE, {1'($urandom), 1'((p % 3) != 1)});
      gen_phase(PhaseOps);
      wait_idle();
    end

    if (channel_results.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived", $time, channel_results.size());
    end
    $display("summary: %0d transactions, %0d ticks with %0d timer expiries,",
             n_items, n_ticks, expiries);
    $display("summary: %0d fetch requests, %0d address wraps, all four regions",
             requests, wraps);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dsc_pkg.sv
hw/rtl/delta_sample_channel_top.sv
tb/tb_top.sv
